// ===== sv/bia_pkg.sv =====
`timescale 1ns / 1ps

package bia_pkg;

    localparam int NUM_BITS  = 1024;
    localparam int SLOT_BITS = 64;
    localparam int ID_W      = 10;
    localparam int CFG_W     = 11;
    localparam int ST_W      = 2;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd1024;

    typedef enum logic
    {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [ST_W-1:0]
    {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } status_t;

    typedef struct packed
    {
        logic valid;
        cmd_t cmd;
    } tok_t;

    typedef struct packed
    {
        logic    valid;
        status_t status;
    } res_t;

endpackage

// ===== sv/bia_if.sv =====
`timescale 1ns / 1ps

interface bia_req_if;
    import bia_pkg::*;

    logic            valid;
    logic            ready;
    logic            command;
    logic [ID_W-1:0] release_number;

    modport source (output valid, output command, output release_number, input ready);
    modport sink (input valid, input command, input release_number, output ready);
endinterface

interface bia_rsp_if;
    import bia_pkg::*;

    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] granted_number;

    modport source (output valid, output status, output granted_number, input ready);
    modport sink (input valid, input status, input granted_number, output ready);
endinterface

interface bia_cfg_if;
    import bia_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] numbers_in_use;

    modport source (output valid, output numbers_in_use, input ready);
    modport sink (input valid, input numbers_in_use, output ready);
endinterface

// ===== sv/bitmap_id_allocator_top.sv =====
`timescale 1ns / 1ps
// Bitmap number allocator, lowest free number first.
// Channels: req (command, release_number), rsp (status, granted_number),
// cfg (numbers_in_use, always ready, write only while idle).
// The bitmap lives in a row of cells, one SLOT_BITS-wide slot each. An
// accepted request enters cell 0 and moves one cell per cycle until the cell
// that owns the answer acts on its slot and reports.
// Path: a request answered by cell k is registered in cells 0 through k and
// then in the output register, or in the hold stage while rsp stalls; a release
// out of range skips the row. An allocate stops at the first slot that holds a
// free number, at the first slot whose last number is at or above the limit, or
// at the last slot. Issue: one request in the row at a time; the next is taken
// the cycle after the previous result is registered, unless it parks in hold.
// Stall: rsp has an output register plus one hold stage, so a result parks
// while rsp.ready is low; req.ready drops only while a request is walking
// the row or a result sits in the hold stage.
// Reset: every number is free and numbers_in_use is 1024.
module bitmap_id_allocator_top #(
    parameter int NUM_BITS  = bia_pkg::NUM_BITS,
    parameter int SLOT_BITS = bia_pkg::SLOT_BITS
) (
    input logic      clk,
    input logic      rst_n,
    bia_req_if.sink  req,
    bia_rsp_if.source rsp,
    bia_cfg_if.sink  cfg
);
    import bia_pkg::*;

    localparam int NUM_SLOTS = (NUM_BITS + SLOT_BITS - 1) / SLOT_BITS;
    localparam int NW        = $clog2(NUM_BITS);
    localparam int LIM_W     = $clog2(NUM_BITS + 1);
    localparam int LW        = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    logic [CFG_W-1:0] limit_reg;
    logic [LW-1:0]    lim_ext;
    logic [LW-1:0]    rel_ext;
    logic [LIM_W-1:0] lim;

    logic acc;
    logic range_err;
    logic inject;

    tok_t          ctok [NUM_SLOTS+1];
    logic [NW-1:0] cnum [NUM_SLOTS+1];
    res_t          cres [NUM_SLOTS];
    logic [NW-1:0] cgrant [NUM_SLOTS];

    logic            chain_v;
    logic [ST_W-1:0] chain_st;
    logic [NW-1:0]   chain_g;
    logic [LW-1:0]   chain_g_ext;

    logic            new_v;
    status_t         new_st;
    logic [ID_W-1:0] new_g;

    logic            inflight_reg;
    logic            inflight_next;
    logic            out_valid_reg;
    status_t         out_st_reg;
    logic [ID_W-1:0] out_g_reg;
    logic            hold_valid_reg;
    status_t         hold_st_reg;
    logic [ID_W-1:0] hold_g_reg;
    logic            out_free;

    assign cfg.ready = 1'b1;
    assign req.ready = !inflight_reg && !hold_valid_reg;
    assign acc       = req.valid && req.ready;

    always_comb
    begin
        if (LW'(limit_reg) > LW'(NUM_BITS))
        begin
            lim_ext = LW'(NUM_BITS);
        end
        else
        begin
            lim_ext = LW'(limit_reg);
        end
        lim       = lim_ext[LIM_W-1:0];
        rel_ext   = LW'(req.release_number);
        range_err = acc && (cmd_t'(req.command) == CMD_RELEASE) && (rel_ext >= lim_ext);
        inject    = acc && !range_err;
    end

    assign ctok[0].valid = inject;
    assign ctok[0].cmd   = cmd_t'(req.command);
    assign cnum[0]       = rel_ext[NW-1:0];

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        bia_cell #(
            .SLOT_BITS (SLOT_BITS),
            .INDEX     (i),
            .NUM_SLOTS (NUM_SLOTS),
            .NW        (NW),
            .LIM_W     (LIM_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .lim     (lim),
            .tok_in  (ctok[i]),
            .num_in  (cnum[i]),
            .tok_out (ctok[i+1]),
            .num_out (cnum[i+1]),
            .res     (cres[i]),
            .grant   (cgrant[i])
        );
    end

    always_comb
    begin
        chain_v  = 1'b0;
        chain_st = '0;
        chain_g  = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (cres[i].valid)
            begin
                chain_v  = 1'b1;
                chain_st = chain_st | cres[i].status;
                chain_g  = chain_g | cgrant[i];
            end
        end
        chain_g_ext = LW'(chain_g);
        new_v       = chain_v || range_err;
        new_st      = range_err ? ST_RANGE : status_t'(chain_st);
        new_g       = range_err ? '0 : chain_g_ext[ID_W-1:0];
        out_free    = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        inflight_next = inflight_reg;
        if (inject)
        begin
            inflight_next = 1'b1;
        end
        else if (chain_v)
        begin
            inflight_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_RESET;
            inflight_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.numbers_in_use;
            end
            priority if (hold_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_reg  <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end
            end
            else if (new_v)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    hold_valid_reg <= 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_valid_reg)
        begin
            if (out_free)
            begin
                out_st_reg <= hold_st_reg;
                out_g_reg  <= hold_g_reg;
            end
        end
        else if (new_v)
        begin
            if (out_free)
            begin
                out_st_reg <= new_st;
                out_g_reg  <= new_g;
            end
            else
            begin
                hold_st_reg <= new_st;
                hold_g_reg  <= new_g;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_st_reg;
    assign rsp.granted_number = out_g_reg;

endmodule

// ===== sv/bia_cell.sv =====
`timescale 1ns / 1ps

module bia_cell #(
    parameter int SLOT_BITS = 64,
    parameter int INDEX     = 0,
    parameter int NUM_SLOTS = 16,
    parameter int NW        = 10,
    parameter int LIM_W     = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LIM_W-1:0]  lim,
    input  bia_pkg::tok_t     tok_in,
    input  logic [NW-1:0]     num_in,
    output bia_pkg::tok_t     tok_out,
    output logic [NW-1:0]     num_out,
    output bia_pkg::res_t     res,
    output logic [NW-1:0]     grant
);
    import bia_pkg::*;

    localparam int BASE = INDEX * SLOT_BITS;
    localparam int BW   = $clog2(SLOT_BITS);
    localparam int CW   = LIM_W + 1;
    localparam bit LAST = (INDEX == NUM_SLOTS - 1);

    tok_t                 tok_reg;
    logic [NW-1:0]        num_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [SLOT_BITS-1:0] slot_next;

    logic [SLOT_BITS-1:0] allow;
    logic [SLOT_BITS-1:0] free;
    logic [BW-1:0]        idx;
    logic                 found;
    logic                 hit;
    logic [CW-1:0]        num_ext;
    logic [CW-1:0]        rbit_w;
    logic [BW-1:0]        rbit;
    logic [CW-1:0]        grant_w;

    always_comb
    begin
        for (int j = 0; j < SLOT_BITS; j++)
        begin
            allow[j] = CW'(BASE + j) < CW'(lim);
        end
        free  = ~slot_reg & allow;
        found = |free;
        idx   = '0;
        for (int j = SLOT_BITS - 1; j >= 0; j--)
        begin
            if (free[j])
            begin
                idx = BW'(j);
            end
        end
        num_ext = CW'(num_reg);
        hit     = (num_ext >= CW'(BASE)) && (num_ext < CW'(BASE + SLOT_BITS));
        rbit_w  = num_ext - CW'(BASE);
        rbit    = rbit_w[BW-1:0];
        grant_w = CW'(BASE) + CW'(idx);
    end

    always_comb
    begin
        slot_next     = slot_reg;
        tok_out.valid = 1'b0;
        tok_out.cmd   = tok_reg.cmd;
        num_out       = num_reg;
        res.valid     = 1'b0;
        res.status    = ST_OK;
        grant         = '0;
        if (tok_reg.valid)
        begin
            unique case (tok_reg.cmd)
                CMD_ALLOC:
                begin
                    if (found)
                    begin
                        slot_next[idx] = 1'b1;
                        res.valid      = 1'b1;
                        res.status     = ST_OK;
                        grant          = grant_w[NW-1:0];
                    end
                    else if (LAST || !allow[SLOT_BITS-1])
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        tok_out.valid = 1'b1;
                    end
                end
                CMD_RELEASE:
                begin
                    if (hit)
                    begin
                        res.valid = 1'b1;
                        if (slot_reg[rbit])
                        begin
                            slot_next[rbit] = 1'b0;
                            res.status      = ST_OK;
                        end
                        else
                        begin
                            res.status = ST_ALREADY_FREE;
                        end
                    end
                    else
                    begin
                        tok_out.valid = 1'b1;
                    end
                end
                default:
                begin
                    tok_out.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
            tok_reg.cmd   <= CMD_ALLOC;
            slot_reg      <= '0;
        end
        else
        begin
            tok_reg  <= tok_in;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_in;
    end

endmodule

// ===== bench/tb_bitmap_id_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_bitmap_id_allocator_top;
    import bia_pkg::*;

    localparam int NUM_SLOTS  = NUM_BITS / SLOT_BITS;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 250;

    typedef struct {
        status_t         status;
        logic [ID_W-1:0] granted;
    } grant_t;

    class id_pool_scoreboard;
        bit [SLOT_BITS-1:0] used_slots [NUM_SLOTS];
        logic [CFG_W-1:0]   limit_reg;
        grant_t             expected_grants [$];
        int                 errors;

        function new();
            foreach (used_slots[i])
                used_slots[i] = '0;
            limit_reg = LIMIT_RESET;
            errors    = 0;
        endfunction

        function bit is_used(int unsigned n);
            return used_slots[n / SLOT_BITS][n % SLOT_BITS];
        endfunction

        // accepted request: update the pool and queue the expected response
        function void note_request(cmd_t cmd, logic [ID_W-1:0] number);
            grant_t      r;
            int unsigned lim;
            int unsigned n;
            lim       = (limit_reg > NUM_BITS) ? NUM_BITS : limit_reg;
            r.status  = ST_FULL;
            r.granted = '0;
            if (cmd == CMD_ALLOC) begin
                for (n = 0; n < lim; n++) begin
                    if (!is_used(n)) begin
                        used_slots[n / SLOT_BITS][n % SLOT_BITS] = 1'b1;
                        r.granted = ID_W'(n);
                        r.status  = ST_OK;
                        break;
                    end
                end
            end
            else if (number >= lim)
                r.status = ST_RANGE;
            else if (!is_used(number))
                r.status = ST_ALREADY_FREE;
            else begin
                used_slots[number / SLOT_BITS][number % SLOT_BITS] = 1'b0;
                r.status = ST_OK;
            end
            expected_grants.push_back(r);
        endfunction

        function void check_response(logic [ST_W-1:0] status, logic [ID_W-1:0] granted);
            grant_t r;
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected response, status %0d granted %0d",
                         $time, status, granted);
                errors++;
                return;
            end
            r = expected_grants.pop_front();
            if (status !== r.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, r.status, status);
                errors++;
            end
            if (granted !== r.granted) begin
                $display("%0t: granted_number mismatch, expected %0d, actual %0d",
                         $time, r.granted, granted);
                errors++;
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        // random number currently marked used, or -1 if none
        function int pick_used();
            int unsigned n;
            int          cnt;
            int          k;
            cnt = 0;
            for (n = 0; n < NUM_BITS; n++)
                if (is_used(n))
                    cnt++;
            if (cnt == 0)
                return -1;
            k = $urandom_range(0, cnt - 1);
            for (n = 0; n < NUM_BITS; n++) begin
                if (is_used(n)) begin
                    if (k == 0)
                        return n;
                    k--;
                end
            end
            return -1;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bia_req_if req_ch ();
    bia_rsp_if rsp_ch ();
    bia_cfg_if cfg_ch ();

    bitmap_id_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    id_pool_scoreboard sb;
    int burst_left     = 0;
    int responses_seen = 0;
    bit long_hold_done = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send_request(cmd_t cmd, logic [ID_W-1:0] number);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.release_number <= number;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(cmd, number);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] value);
        drain();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.numbers_in_use <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.limit_reg = value;
    endtask

    task automatic run_random(int count, int alloc_pct);
        int i;
        int pick;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < alloc_pct)
                send_request(CMD_ALLOC, ID_W'($urandom_range(0, NUM_BITS - 1)));
            else begin
                pick = sb.pick_used();
                if (pick >= 0 && $urandom_range(0, 9) < 6)
                    send_request(CMD_RELEASE, ID_W'(pick));
                else
                    send_request(CMD_RELEASE, ID_W'($urandom_range(0, NUM_BITS - 1)));
            end
        end
    endtask

    // response side: check and stall
    initial
    begin
        int mode;
        int left;
        int hold;
        mode = 0;
        left = 0;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                sb.check_response(rsp_ch.status, rsp_ch.granted_number);
                responses_seen++;
            end
            if (!long_hold_done && responses_seen >= 400) begin
                long_hold_done = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog
    initial
    begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, idle);
                $display("tb_bitmap_id_allocator_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int ph_limit [8];
        int ph_count [8];
        int ph_alloc [8];
        int p;
        ph_limit = '{1024, 65, 1, 2047, 1000, 0, 0, 64};
        ph_count = '{200, 200, 80, 900, 250, 40, 150, 130};
        ph_alloc = '{60, 55, 50, 95, 80, 50, 50, 60};
        ph_limit[6] = $urandom_range(1, NUM_BITS);

        sb = new();
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.command        <= CMD_ALLOC;
        req_ch.release_number <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.numbers_in_use <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        write_limit(11'd1024);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_RELEASE, 10'd1);
        send_request(CMD_RELEASE, 10'd1);
        send_request(CMD_RELEASE, 10'd1023);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_RELEASE, 10'd0);

        // zero limit
        write_limit(11'd0);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_RELEASE, 10'd0);
        send_request(CMD_RELEASE, 10'd1023);

        // limit lowered below numbers in use
        write_limit(11'd1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_RELEASE, 10'd1);
        send_request(CMD_RELEASE, 10'd0);

        // limit above capacity
        write_limit(11'd2047);
        send_request(CMD_RELEASE, 10'd1023);
        send_request(CMD_ALLOC, '1);

        write_limit(11'd2);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_RELEASE, 10'd2);

        for (p = 0; p < 8; p++) begin
            write_limit(CFG_W'(ph_limit[p]));
            run_random(ph_count[p], ph_alloc[p]);
        end

        drain();
        repeat (NUM_SLOTS + 8) @(posedge clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d responses never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb_bitmap_id_allocator_top: done, clean");
        else
            $display("tb_bitmap_id_allocator_top: done, errors");
        $finish;
    end

endmodule
